@@ rtl/core/occupancy_grid_stamp_core_macros.svh @@
// Assertion macros used by the checker of the occupancy grid core.
`ifndef OCCUPANCY_GRID_STAMP_CORE_MACROS_SVH
`define OCCUPANCY_GRID_STAMP_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OGS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define OGS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// As above, but also checked while reset is high.
`define OGS_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/ogs_pkg.sv @@
// Package of the occupancy grid core: types, codes, defaults and the sine table.
package ogs_pkg;

  localparam int DEF_MAX_COLS     = 64;
  localparam int DEF_MAX_ROWS     = 64;
  localparam int DEF_STAMP_RADIUS = 2;

  // Signed width of a grid coordinate after the polar conversion.
  localparam int CW = 21;

  localparam logic [6:0]  RST_GRID_WIDTH  = 7'd64;
  localparam logic [6:0]  RST_GRID_HEIGHT = 7'd64;
  localparam logic [5:0]  RST_ORIGIN_COL  = 6'd32;
  localparam logic [5:0]  RST_ORIGIN_ROW  = 6'd32;
  localparam logic [15:0] RST_CPM         = 16'd2560;
  localparam logic [23:0] RST_DECAY       = 24'd5000;
  localparam logic [23:0] TICK_MAX        = 24'hFFFFFF;

  typedef enum logic [2:0] {
    CFG_GRID_WIDTH  = 3'd0,
    CFG_GRID_HEIGHT = 3'd1,
    CFG_ORIGIN_COL  = 3'd2,
    CFG_ORIGIN_ROW  = 3'd3,
    CFG_CPM         = 3'd4,
    CFG_DECAY       = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_STAMP = 2'd1,
    MODE_QUERY = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TICK,
    ST_ECHO,
    ST_MUL1,
    ST_MUL2,
    ST_COORD,
    ST_CHECK,
    ST_ROW,
    ST_RMW,
    ST_QRD,
    ST_QVAL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic echo;
    logic axis;
    logic mul1;
    logic mul2;
    logic coord;
    logic stamp_init;
    logic ram_rd;
    logic ram_wr;
    logic row_next;
    logic clr_wr;
    logic tick;
    logic qrd;
    logic qval;
    logic res_load;
  } ogs_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  dist_zero;
    logic  in_bounds;
    logic  row_ok;
    logic  last_dr;
    logic  clr_last;
    logic  tick_clear;
  } ogs_status_t;

  localparam logic [15:0] QSINE [0:64] = '{
    16'd0,     16'd804,   16'd1608,  16'd2410,  16'd3212,  16'd4011,  16'd4808,
    16'd5602,  16'd6393,  16'd7179,  16'd7962,  16'd8739,  16'd9512,  16'd10278,
    16'd11039, 16'd11793, 16'd12539, 16'd13279, 16'd14010, 16'd14732, 16'd15446,
    16'd16151, 16'd16846, 16'd17530, 16'd18204, 16'd18868, 16'd19519, 16'd20159,
    16'd20787, 16'd21403, 16'd22005, 16'd22594, 16'd23170, 16'd23731, 16'd24279,
    16'd24811, 16'd25329, 16'd25832, 16'd26319, 16'd26790, 16'd27245, 16'd27683,
    16'd28105, 16'd28510, 16'd28898, 16'd29268, 16'd29621, 16'd29956, 16'd30273,
    16'd30571, 16'd30852, 16'd31113, 16'd31356, 16'd31580, 16'd31785, 16'd31971,
    16'd32137, 16'd32285, 16'd32412, 16'd32521, 16'd32609, 16'd32678, 16'd32728,
    16'd32757, 16'd32767
  };

  // Sine of one of 256 steps per turn, signed Q1.15 held in 17 bits.
  function automatic logic signed [16:0] sine_step(input logic [7:0] step);
    logic [6:0]  k;
    logic [15:0] mag;
    logic signed [16:0] v;
    k   = {1'b0, step[5:0]};
    mag = step[6] ? QSINE[7'd64 - k] : QSINE[k];
    v   = $signed({1'b0, mag});
    return step[7] ? -v : v;
  endfunction

endpackage

@@ rtl/core/ogs_ram.sv @@
// Generic single-port RAM with registered read data.
module ogs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ rtl/core/ogs_ctrl.sv @@
// Sequencing state machine of the occupancy grid core.
module ogs_ctrl
  import ogs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  ogs_status_t sts,
  output ogs_cmd_t    cmd
);

  state_t state, state_next;
  logic   echo, echo_next;
  logic   axis, axis_next;
  logic   pending, pending_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      echo      <= 1'b0;
      axis      <= 1'b0;
      pending   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      echo      <= echo_next;
      axis      <= axis_next;
      pending   <= pending_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next     = state;
    echo_next      = echo;
    axis_next      = axis;
    pending_next   = pending;
    out_valid_next = out_valid && out_stall;
    cmd            = '0;
    cmd.echo       = echo;
    cmd.axis       = axis;
    in_stall       = 1'b1;
    case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_next = pending ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture  = 1'b1;
          pending_next = 1'b1;
          echo_next    = 1'b0;
          axis_next    = 1'b0;
          case (sts.mode)
            MODE_TICK:  state_next = ST_TICK;
            MODE_STAMP: state_next = ST_ECHO;
            MODE_QUERY: state_next = ST_QRD;
            default:    state_next = ST_DONE;
          endcase
        end
      end
      ST_TICK: begin
        cmd.tick   = 1'b1;
        state_next = sts.tick_clear ? ST_CLEAR : ST_DONE;
      end
      ST_ECHO: begin
        axis_next = 1'b0;
        if (!sts.dist_zero) begin
          state_next = ST_MUL1;
        end else if (echo) begin
          state_next = ST_DONE;
        end else begin
          echo_next = 1'b1;
        end
      end
      ST_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = ST_COORD;
      end
      ST_COORD: begin
        cmd.coord = 1'b1;
        if (!axis) begin
          axis_next  = 1'b1;
          state_next = ST_MUL1;
        end else begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts.in_bounds) begin
          cmd.stamp_init = 1'b1;
          state_next     = ST_ROW;
        end else if (echo) begin
          state_next = ST_DONE;
        end else begin
          echo_next  = 1'b1;
          state_next = ST_ECHO;
        end
      end
      ST_ROW: begin
        if (sts.row_ok) begin
          cmd.ram_rd = 1'b1;
          state_next = ST_RMW;
        end else begin
          cmd.row_next = 1'b1;
          if (sts.last_dr) begin
            echo_next  = 1'b1;
            state_next = echo ? ST_DONE : ST_ECHO;
          end
        end
      end
      ST_RMW: begin
        cmd.ram_wr   = 1'b1;
        cmd.row_next = 1'b1;
        if (sts.last_dr) begin
          echo_next  = 1'b1;
          state_next = echo ? ST_DONE : ST_ECHO;
        end else begin
          state_next = ST_ROW;
        end
      end
      ST_QRD: begin
        cmd.qrd    = 1'b1;
        state_next = ST_QVAL;
      end
      ST_QVAL: begin
        cmd.qval   = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.res_load   = 1'b1;
          out_valid_next = 1'b1;
          pending_next   = 1'b0;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/ogs_dp.sv @@
// Datapath of the occupancy grid core: registers, coordinate arithmetic and grid RAM.
module ogs_dp
  import ogs_pkg::*;
#(
  parameter int MAX_COLS     = DEF_MAX_COLS,
  parameter int MAX_ROWS     = DEF_MAX_ROWS,
  parameter int STAMP_RADIUS = DEF_STAMP_RADIUS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic [1:0]  mode,
  input  logic [15:0] fwd_distance,
  input  logic [15:0] fwd_angle,
  input  logic [15:0] rot_distance,
  input  logic [15:0] rot_angle,
  input  logic [5:0]  query_col,
  input  logic [5:0]  query_row,
  input  ogs_cmd_t    cmd,
  output ogs_status_t sts,
  output logic        cell_value,
  output logic        grid_cleared,
  output logic [5:0]  cells_marked
);

  localparam int RW   = $clog2(MAX_ROWS);
  localparam int COLW = $clog2(MAX_COLS);
  localparam int SIDE = 2 * STAMP_RADIUS + 1;
  localparam int DRW  = $clog2(SIDE + 1);
  localparam int NW   = $clog2(SIDE + 1);
  localparam int AW   = $clog2(2 * SIDE * SIDE + 1);
  localparam logic signed [CW-1:0] MAXC = CW'(MAX_COLS);
  localparam logic signed [CW-1:0] MAXR = CW'(MAX_ROWS);
  localparam logic signed [CW-1:0] RAD  = CW'(STAMP_RADIUS);
  localparam logic [DRW-1:0]       LAST_DR = DRW'(SIDE - 1);
  localparam logic [RW-1:0]        LAST_ROW = RW'(MAX_ROWS - 1);

  // Configuration.
  logic [6:0]  grid_width, grid_height;
  logic [5:0]  origin_col, origin_row;
  logic [15:0] cpm;
  logic [23:0] decay;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= RST_GRID_WIDTH;
      grid_height <= RST_GRID_HEIGHT;
      origin_col  <= RST_ORIGIN_COL;
      origin_row  <= RST_ORIGIN_ROW;
      cpm         <= RST_CPM;
      decay       <= RST_DECAY;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_GRID_WIDTH:  grid_width  <= cfg_data[6:0];
        CFG_GRID_HEIGHT: grid_height <= cfg_data[6:0];
        CFG_ORIGIN_COL:  origin_col  <= cfg_data[5:0];
        CFG_ORIGIN_ROW:  origin_row  <= cfg_data[5:0];
        CFG_CPM:         cpm         <= cfg_data[15:0];
        CFG_DECAY:       decay       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Grid extent in use, clipped to the store.
  logic signed [CW-1:0] w_used, h_used, gw_ext, gh_ext;
  assign gw_ext = CW'({1'b0, grid_width});
  assign gh_ext = CW'({1'b0, grid_height});
  assign w_used = (gw_ext > MAXC) ? MAXC : gw_ext;
  assign h_used = (gh_ext > MAXR) ? MAXR : gh_ext;

  // Captured request.
  logic [1:0]  mode_q;
  logic [15:0] fd, fa, rd, ra;
  logic [5:0]  qc, qr;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q <= mode;
      fd <= fwd_distance;
      fa <= fwd_angle;
      rd <= rot_distance;
      ra <= rot_angle;
      qc <= query_col;
      qr <= query_row;
    end
  end

  // Polar to grid conversion, one axis at a time: cosine gives the column.
  logic [15:0] echo_dist, angle;
  logic [7:0]  step;
  logic signed [16:0] trig;
  logic signed [33:0] p1;
  logic signed [50:0] p2;
  logic signed [51:0] s, s_adj;
  logic [5:0]  org;
  logic signed [CW-1:0] q, gc, gr;

  assign echo_dist = cmd.echo ? rd : fd;
  assign angle     = cmd.echo ? ra : fa;
  assign step  = cmd.axis ? angle[15:8] : angle[15:8] + 8'd64;
  assign trig  = sine_step(step);
  assign org   = cmd.axis ? origin_row : origin_col;
  assign s     = 52'(p2) + $signed({15'd0, org, 31'd0});
  // Truncation toward zero: bias negative sums up before the shift.
  assign s_adj = s[51] ? s + 52'sh7FFFFFFF : s;
  assign q     = s_adj[CW+30:31];

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      p1 <= $signed({1'b0, echo_dist}) * trig;
    end
    if (cmd.mul2) begin
      p2 <= p1 * $signed({1'b0, cpm});
    end
    if (cmd.coord) begin
      if (cmd.axis) begin
        gr <= q;
      end else begin
        gc <= q;
      end
    end
  end

  // Stamp bookkeeping.
  logic signed [CW-1:0] lo, hi, cur_row, lo_n, hi_n;
  logic [DRW-1:0] dr;
  logic [AW-1:0]  acc;
  logic [NW-1:0]  ncols;
  logic [MAX_COLS-1:0] mask, rdata, wdata;
  logic [RW-1:0]  clr_cnt, addr;
  logic           we;
  logic           cleared_w, cell_w;
  logic [23:0]    elapsed, e_inc;
  logic signed [CW-1:0] qc_ext, qr_ext;
  logic           q_ok;

  assign lo_n  = (gc - RAD < 0) ? '0 : gc - RAD;
  assign hi_n  = (gc + RAD > w_used - 1) ? w_used - 1 : gc + RAD;
  assign ncols = NW'(hi - lo + 1);

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      mask[c] = (CW'(c) >= lo) && (CW'(c) <= hi);
    end
  end

  assign qc_ext = CW'({1'b0, qc});
  assign qr_ext = CW'({1'b0, qr});
  assign q_ok   = (qc_ext < w_used) && (qr_ext < h_used);
  assign e_inc  = (elapsed == TICK_MAX) ? elapsed : elapsed + 24'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
      elapsed <= '0;
    end else begin
      if (cmd.clr_wr) begin
        clr_cnt <= (clr_cnt == LAST_ROW) ? '0 : clr_cnt + RW'(1);
      end
      if (cmd.tick) begin
        elapsed <= sts.tick_clear ? '0 : e_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      acc       <= '0;
      cleared_w <= 1'b0;
      cell_w    <= 1'b0;
    end
    if (cmd.tick) begin
      cleared_w <= sts.tick_clear;
    end
    if (cmd.qval) begin
      cell_w <= q_ok & rdata[qc_ext[COLW-1:0]];
    end
    if (cmd.stamp_init) begin
      lo      <= lo_n;
      hi      <= hi_n;
      cur_row <= gr - RAD;
      dr      <= '0;
    end
    if (cmd.ram_wr) begin
      acc <= acc + AW'(ncols);
    end
    if (cmd.row_next) begin
      cur_row <= cur_row + CW'(1);
      dr      <= dr + DRW'(1);
    end
    if (cmd.res_load) begin
      cell_value   <= cell_w;
      grid_cleared <= cleared_w;
      cells_marked <= (acc > AW'(63)) ? 6'd63 : acc[5:0];
    end
  end

  // Grid store, one row of cells per word.
  always_comb begin
    if (cmd.clr_wr) begin
      addr = clr_cnt;
    end else if (cmd.qrd) begin
      addr = qr_ext[RW-1:0];
    end else begin
      addr = cur_row[RW-1:0];
    end
  end
  assign we    = cmd.clr_wr | cmd.ram_wr;
  assign wdata = cmd.clr_wr ? '0 : (rdata | mask);

  ogs_ram #(.WIDTH(MAX_COLS), .DEPTH(MAX_ROWS)) u_ram (
    .clk   (clk),
    .we    (we),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  // Status.
  assign sts.mode       = mode_t'(cmd.capture ? mode : mode_q);
  assign sts.dist_zero  = (echo_dist == 16'd0);
  assign sts.in_bounds  = (gc >= 0) && (gc < w_used) && (gr >= 0) && (gr < h_used);
  assign sts.row_ok     = (cur_row >= 0) && (cur_row < h_used);
  assign sts.last_dr    = (dr == LAST_DR);
  assign sts.clr_last   = (clr_cnt == LAST_ROW);
  assign sts.tick_clear = (e_inc > decay);

endmodule

@@ rtl/core/occupancy_grid_stamp_core.sv @@
// Top level of the occupancy grid core: controller, datapath and ports.
//
//  Channel   Handshake             Payload
//  in        in_valid / in_stall   mode, fwd/rot distance and angle, query_col/row
//  out       out_valid / out_stall cell_value, grid_cleared, cells_marked
//  config    cfg_write             cfg_index, cfg_data
//
// Requests are handled one at a time by a state machine driving a shared
// datapath. A tick can clear the grid; the clear writes one RAM row per cycle.
// In a sonar reading each echo needs two passes through the two chained
// multipliers and a bounds check, then a read-modify-write of the row RAM per
// stamped row; an echo with no distance is skipped. After reset the RAM is
// zeroed in a pass over all rows, during which in_stall stays high. A finished
// result sits in the output register while the next request is accepted; a
// stalled result only holds back the request after.
module occupancy_grid_stamp_core
  import ogs_pkg::*;
#(
  parameter int MAX_COLS     = DEF_MAX_COLS,
  parameter int MAX_ROWS     = DEF_MAX_ROWS,
  parameter int STAMP_RADIUS = DEF_STAMP_RADIUS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [15:0] fwd_distance,
  input  logic [15:0] fwd_angle,
  input  logic [15:0] rot_distance,
  input  logic [15:0] rot_angle,
  input  logic [5:0]  query_col,
  input  logic [5:0]  query_row,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        cell_value,
  output logic        grid_cleared,
  output logic [5:0]  cells_marked
);

  ogs_cmd_t    cmd;
  ogs_status_t sts;

  // The controller owns sequencing and both handshakes.
  ogs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds configuration, the tick count, arithmetic and the grid.
  ogs_dp #(
    .MAX_COLS     (MAX_COLS),
    .MAX_ROWS     (MAX_ROWS),
    .STAMP_RADIUS (STAMP_RADIUS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mode         (mode),
    .fwd_distance (fwd_distance),
    .fwd_angle    (fwd_angle),
    .rot_distance (rot_distance),
    .rot_angle    (rot_angle),
    .query_col    (query_col),
    .query_row    (query_row),
    .cmd          (cmd),
    .sts          (sts),
    .cell_value   (cell_value),
    .grid_cleared (grid_cleared),
    .cells_marked (cells_marked)
  );

endmodule

@@ rtl/core/ogs_checker.sv @@
// Port-level checker of the occupancy grid core and its bind.
`include "occupancy_grid_stamp_core_macros.svh"

module ogs_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       cell_value,
  input logic       grid_cleared,
  input logic [5:0] cells_marked
);

  `OGS_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
  `OGS_ASSERT_NEXT_ALWAYS(a_clear_after_reset, clk, rst, in_stall)
  `OGS_ASSERT_SAME(a_one_kind, clk, rst, out_valid && (cells_marked != 6'd0), !grid_cleared && !cell_value)
  `OGS_ASSERT_NEXT(a_hold, clk, rst, out_valid && out_stall, out_valid && $stable(cells_marked))

endmodule

bind occupancy_grid_stamp_core ogs_checker u_ogs_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .cell_value   (cell_value),
  .grid_cleared (grid_cleared),
  .cells_marked (cells_marked)
);
